[design/assert_macros.svh]
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is released
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/chs_pkg.sv]
package chs_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] OUT_DONE     = 2'd0;
	localparam logic [1:0] OUT_MISSING  = 2'd1;
	localparam logic [1:0] OUT_POOL_FULL = 2'd2;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_CLEAR  = 11'b00000000010,
		ST_HEAD   = 11'b00000000100,
		ST_INS    = 11'b00000001000,
		ST_RD     = 11'b00000010000,
		ST_CMP    = 11'b00000100000,
		ST_UNLINK = 11'b00001000000,
		ST_FREE   = 11'b00010000000,
		ST_RES    = 11'b00100000000,
		ST_WAIT   = 11'b01000000000,
		ST_HASH   = 11'b10000000000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic hash;
		logic clear_step;
		logic head_rd;
		logic do_insert;
		logic node_rd;
		logic advance;
		logic unlink;
		logic free_node;
		logic set_result;
		logic [1:0] result_code;
		logic result_bucket;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic pool_empty;
		logic cur_null;
		logic key_match;
		logic steps_done;
		logic [1:0] mode;
	} status_t;

endpackage

[design/chs_datapath.sv]
`include "assert_macros.svh"

module chs_datapath #(
	parameter int BUCKETS = 16,
	parameter int NODES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [1:0] mode,
	input  logic signed [31:0] key,
	input  chs_pkg::cmd_t cmd,
	output chs_pkg::status_t status,
	output logic [1:0] outcome,
	output logic [3:0] bucket
);

	localparam int NW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW = (NODES > BUCKETS) ? NW : BW;
	localparam logic [LW-1:0] NIL = LW'(NODES);

	// storage: links and keys in memory; heads in memory, cleared after reset
	logic [31:0] keys_mem [NODES];
	logic [LW-1:0] link_mem [NODES];
	logic [LW-1:0] head_mem [BUCKETS];

	logic [1:0] mode_q;
	logic [31:0] key_q;
	logic [31:0] mag_q;
	logic [BW-1:0] b_q;
	logic [LW-1:0] cur_q, prev_q, free_q, head_q;
	logic [31:0] rkey_q;
	logic [LW-1:0] rlink_q;
	logic [LW:0] steps_q;
	logic [CW:0] clr_q;
	logic [1:0] outcome_q;
	logic [3:0] bucket_q;

	logic [31:0] mag;
	logic [BW-1:0] bidx;
	logic [NW-1:0] cur_i, prev_i, free_i;

	// key magnitude, registered with the request
	assign mag = key[31] ? (32'd0 - 32'(key)) : 32'(key);
	assign cur_i = cur_q[NW-1:0];
	assign prev_i = prev_q[NW-1:0];
	assign free_i = free_q[NW-1:0];

	// bucket index: low bits for a power of two, else reciprocal multiplication
	generate
		if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
			assign bidx = mag_q[BW-1:0];
		end else begin : g_recip
			localparam logic [63:0] RECIP =
				((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
			logic [65:0] prod;
			logic [31:0] quot;
			logic [31:0] qb;
			assign prod = 66'(mag_q) * 66'(RECIP[32:0]);
			assign quot = 32'(prod >> (32 + BW));
			assign qb = quot * 32'(BUCKETS);
			assign bidx = mag_q[BW-1:0] - qb[BW-1:0];
		end
	endgenerate

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			free_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.do_insert) begin
				free_q <= rlink_q;
			end else if (cmd.free_node) begin
				free_q <= cur_q;
			end
		end
	end

	// request capture, walk registers, memory ports
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q <= mode;
			key_q <= 32'(key);
			mag_q <= mag;
			steps_q <= '0;
			prev_q <= NIL;
		end
		if (cmd.hash) begin
			b_q <= bidx;
		end
		if (cmd.clear_step) begin
			if (clr_q < (CW+1)'(BUCKETS)) begin
				head_mem[clr_q[BW-1:0]] <= NIL;
			end
			if (clr_q < (CW+1)'(NODES)) begin
				link_mem[clr_q[NW-1:0]] <= LW'(clr_q) + 1'b1;
			end
		end
		if (cmd.head_rd) begin
			head_q <= head_mem[b_q];
			cur_q <= head_mem[b_q];
			rlink_q <= link_mem[free_i];
		end
		if (cmd.do_insert) begin
			keys_mem[free_i] <= key_q;
			link_mem[free_i] <= head_q;
			head_mem[b_q] <= free_q;
		end
		if (cmd.node_rd) begin
			rkey_q <= keys_mem[cur_i];
			rlink_q <= link_mem[cur_i];
		end
		if (cmd.advance) begin
			prev_q <= cur_q;
			cur_q <= rlink_q;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.unlink) begin
			if (prev_q < NIL) begin
				link_mem[prev_i] <= rlink_q;
			end else begin
				head_mem[b_q] <= rlink_q;
			end
		end
		if (cmd.free_node) begin
			link_mem[cur_i] <= free_q;
		end
		if (cmd.set_result) begin
			outcome_q <= cmd.result_code;
			bucket_q <= cmd.result_bucket ? 4'(b_q) : 4'd0;
		end
	end

	assign status.clear_done = (clr_q >= (CW+1)'(NODES)) && (clr_q >= (CW+1)'(BUCKETS));
	assign status.pool_empty = !(free_q < NIL);
	assign status.cur_null = !(cur_q < NIL);
	assign status.key_match = (rkey_q == key_q);
	assign status.steps_done = (steps_q >= (LW+1)'(NODES));
	assign status.mode = mode_q;
	assign outcome = outcome_q;
	assign bucket = bucket_q;

	`ASSERT_NEXT(a_free_moves, clk, arst_n, cmd.free_node, free_q == $past(cur_q), "free head not taken")
	`ASSERT_ALWAYS(a_one_write, clk, arst_n, !(cmd.do_insert && cmd.unlink), "two head writes")

endmodule

[design/chs_ctrl.sv]
`include "assert_macros.svh"

module chs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  chs_pkg::status_t status,
	output chs_pkg::cmd_t cmd
);

	chs_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != chs_pkg::ST_IDLE);
	assign out_valid = (state_q == chs_pkg::ST_WAIT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			chs_pkg::ST_CLEAR: begin
				cmd.clear_step = !status.clear_done;
				if (status.clear_done) begin
					state_d = chs_pkg::ST_IDLE;
				end
			end
			chs_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = chs_pkg::ST_HASH;
				end
			end
			chs_pkg::ST_HASH: begin
				cmd.hash = 1'b1;
				state_d = chs_pkg::ST_HEAD;
			end
			chs_pkg::ST_HEAD: begin
				cmd.head_rd = 1'b1;
				if (status.mode == chs_pkg::MODE_INSERT) begin
					state_d = chs_pkg::ST_INS;
				end else if (status.mode == chs_pkg::MODE_SEARCH ||
						status.mode == chs_pkg::MODE_DELETE) begin
					state_d = chs_pkg::ST_RD;
				end else begin
					cmd.set_result = 1'b1;
					cmd.result_code = chs_pkg::OUT_MISSING;
					state_d = chs_pkg::ST_WAIT;
				end
			end
			chs_pkg::ST_INS: begin
				cmd.set_result = 1'b1;
				if (status.pool_empty) begin
					cmd.result_code = chs_pkg::OUT_POOL_FULL;
				end else begin
					cmd.do_insert = 1'b1;
					cmd.result_code = chs_pkg::OUT_DONE;
				end
				state_d = chs_pkg::ST_WAIT;
			end
			chs_pkg::ST_RD: begin
				if (status.cur_null || status.steps_done) begin
					cmd.set_result = 1'b1;
					cmd.result_code = chs_pkg::OUT_MISSING;
					state_d = chs_pkg::ST_WAIT;
				end else begin
					cmd.node_rd = 1'b1;
					state_d = chs_pkg::ST_CMP;
				end
			end
			chs_pkg::ST_CMP: begin
				if (status.key_match) begin
					cmd.set_result = 1'b1;
					cmd.result_code = chs_pkg::OUT_DONE;
					if (status.mode == chs_pkg::MODE_SEARCH) begin
						cmd.result_bucket = 1'b1;
						state_d = chs_pkg::ST_WAIT;
					end else begin
						state_d = chs_pkg::ST_UNLINK;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d = chs_pkg::ST_RD;
				end
			end
			chs_pkg::ST_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d = chs_pkg::ST_FREE;
			end
			chs_pkg::ST_FREE: begin
				cmd.free_node = 1'b1;
				state_d = chs_pkg::ST_WAIT;
			end
			chs_pkg::ST_RES: begin
				state_d = chs_pkg::ST_WAIT;
			end
			chs_pkg::ST_WAIT: begin
				if (!out_stall) begin
					state_d = chs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chs_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`ASSERT_NEXT(a_take, clk, arst_n, in_valid && !in_stall, state_q == chs_pkg::ST_HASH, "request lost")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")

endmodule

[design/chained_hash_set.sv]
// chained hash set: one request in flight at a time
// insert: hash, head read, then insert or report pool full
// search/delete: hash, head read, then node reads and key compares until a hit or a miss
// a delete hit unlinks and frees the node; an unused mode reports missing after the head read
// reset: asynchronous; then the clear state clears the heads and chains the free list
module chained_hash_set #(
	parameter int BUCKETS = 16,
	parameter int NODES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] mode,
	input  logic signed [31:0] key,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] outcome,
	output logic [3:0] bucket
);

	chs_pkg::cmd_t cmd;
	chs_pkg::status_t status;

	chs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	chs_datapath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .mode(mode), .key(key), .cmd(cmd),
		.status(status), .outcome(outcome), .bucket(bucket)
	);

endmodule

[tb/sv/chained_hash_set_tb.sv]
module chained_hash_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUCKETS = 16;
	localparam int NODES = 256;
	localparam int NIL = NODES;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM = 930;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] key;
	} request_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [3:0] bucket;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic signed [31:0] key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] outcome;
	logic [3:0] bucket;

	chained_hash_set #(.BUCKETS(BUCKETS), .NODES(NODES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.outcome(outcome), .bucket(bucket)
	);

	// shadow hash table
	int heads[BUCKETS];
	logic [31:0] slot_keys[NODES];
	int slot_links[NODES];
	int free_slot;

	request_t pending_requests[$];
	answer_t expected_answers[$];
	logic [31:0] live_keys[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stimulus_done = 1'b0;
	bit calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int bucket_index(logic [31:0] k);
		logic [31:0] mag;
		mag = k[31] ? (32'd0 - k) : k;
		return int'(mag % BUCKETS);
	endfunction

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int b, cur, prev, steps;
		a.outcome = chs_pkg::OUT_MISSING;
		a.bucket = '0;
		b = bucket_index(r.key);
		if (r.mode == chs_pkg::MODE_INSERT) begin
			if (free_slot < NIL) begin
				cur = free_slot;
				free_slot = slot_links[cur];
				slot_keys[cur] = r.key;
				slot_links[cur] = heads[b];
				heads[b] = cur;
				a.outcome = chs_pkg::OUT_DONE;
			end else begin
				a.outcome = chs_pkg::OUT_POOL_FULL;
			end
		end else if (r.mode == chs_pkg::MODE_SEARCH || r.mode == chs_pkg::MODE_DELETE) begin
			cur = heads[b];
			prev = NIL;
			steps = 0;
			while (cur < NIL && steps < NODES) begin
				if (slot_keys[cur] == r.key) begin
					a.outcome = chs_pkg::OUT_DONE;
					if (r.mode == chs_pkg::MODE_SEARCH) begin
						a.bucket = b[3:0];
					end else begin
						if (prev < NIL) slot_links[prev] = slot_links[cur];
						else heads[b] = slot_links[cur];
						slot_links[cur] = free_slot;
						free_slot = cur;
					end
					break;
				end
				prev = cur;
				cur = slot_links[cur];
				steps++;
			end
		end
		return a;
	endfunction

	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4 && live_keys.size() > 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		else if (sel < 7)
			return $urandom_range(0, 63) - 32;
		else if (sel == 7)
			return {1'b1, 31'd0} + $urandom_range(0, 3);
		return $urandom;
	endfunction

	task automatic queue_request(logic [1:0] m, logic [31:0] k);
		request_t r;
		r.mode = m;
		r.key = k;
		pending_requests.push_back(r);
		if (m == chs_pkg::MODE_INSERT) live_keys.push_back(k);
	endtask

	// stimulus: directed corners, then random phases of fill, drain and mixed traffic
	initial begin
		int m, phase_len;
		queue_request(chs_pkg::MODE_SEARCH, 32'd5);
		queue_request(chs_pkg::MODE_DELETE, 32'd5);
		queue_request(chs_pkg::MODE_INSERT, 32'h8000_0000);
		queue_request(chs_pkg::MODE_INSERT, 32'h7fff_ffff);
		queue_request(chs_pkg::MODE_INSERT, 32'hffff_ffff);
		queue_request(chs_pkg::MODE_INSERT, 32'd0);
		queue_request(chs_pkg::MODE_INSERT, 32'd1);
		queue_request(chs_pkg::MODE_INSERT, 32'd17);
		queue_request(chs_pkg::MODE_INSERT, 32'd17);
		queue_request(chs_pkg::MODE_SEARCH, 32'h8000_0000);
		queue_request(chs_pkg::MODE_SEARCH, 32'h7fff_ffff);
		queue_request(chs_pkg::MODE_SEARCH, 32'hffff_ffff);
		queue_request(chs_pkg::MODE_SEARCH, 32'd1);
		queue_request(chs_pkg::MODE_SEARCH, 32'd33);
		queue_request(chs_pkg::MODE_DELETE, 32'd1);
		queue_request(chs_pkg::MODE_DELETE, 32'd17);
		queue_request(chs_pkg::MODE_SEARCH, 32'd17);
		queue_request(chs_pkg::MODE_DELETE, 32'd17);
		queue_request(chs_pkg::MODE_DELETE, 32'd17);
		queue_request(MODE_UNUSED, 32'd0);
		queue_request(MODE_UNUSED, 32'hffff_ffff);
		// random phases; the insert-heavy phase can overflow the pool
		while (pending_requests.size() < N_RANDOM + 21) begin
			phase_len = $urandom_range(40, 320);
			m = $urandom_range(0, 2);
			repeat (phase_len) begin
				int r;
				r = $urandom_range(0, 99);
				if (pending_requests.size() < N_RANDOM + 21) begin
					if (m == 0)
						queue_request(r < 85 ? chs_pkg::MODE_INSERT :
							(r < 95 ? chs_pkg::MODE_SEARCH : chs_pkg::MODE_DELETE),
							pick_key());
					else if (m == 1)
						queue_request(r < 15 ? chs_pkg::MODE_INSERT :
							(r < 55 ? chs_pkg::MODE_SEARCH :
							(r < 97 ? chs_pkg::MODE_DELETE : MODE_UNUSED)), pick_key());
					else
						queue_request(r < 35 ? chs_pkg::MODE_INSERT :
							(r < 70 ? chs_pkg::MODE_SEARCH :
							(r < 98 ? chs_pkg::MODE_DELETE : MODE_UNUSED)), pick_key());
				end
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow state reset
	initial begin
		for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
		for (int i = 0; i < NODES; i++) begin
			slot_keys[i] = '0;
			slot_links[i] = i + 1;
		end
		free_slot = 0;
	end

	// stretch with no idling
	always @(posedge clk) begin
		if (pending_requests.size() == 600) calm <= 1'b1;
		if (pending_requests.size() == 450) calm <= 1'b0;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_answers.push_back(apply_request({mode, key}));
				if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
					{mode, key} <= pending_requests.pop_front();
				end else begin
					in_valid <= 1'b0;
					if (pending_requests.size() == 0) stimulus_done <= 1'b1;
				end
			end else if (!in_valid && pending_requests.size() > 0 &&
					(calm || $urandom_range(0, 99) >= 31)) begin
				in_valid <= 1'b1;
				{mode, key} <= pending_requests.pop_front();
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.outcome = outcome;
				got.bucket = bucket;
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: outcome %0d bucket %0d", outcome, bucket);
				end else begin
					want = expected_answers.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected outcome %0d bucket %0d, ",
								"got outcome %0d bucket %0d"},
								want.outcome, want.bucket, got.outcome, got.bucket);
					end
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 31);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("chained_hash_set test failed");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stimulus_done);
		wait (expected_answers.size() == 0);
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("chained_hash_set test passed");
		else
			$display("chained_hash_set test failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/chs_pkg.sv
design/chs_datapath.sv
design/chs_ctrl.sv
design/chained_hash_set.sv
tb/sv/chained_hash_set_tb.sv
